// ===== hdl/sps_pkg.sv =====
// shared pool multi-stack package: default sizes, command and status codes
// no dependencies; used by shared_pool_multi_stack
`default_nettype none

package sps_pkg;

   // default configuration of the pool
   localparam int NUM_STACKS_DEF = 8;
   localparam int NUM_SLOTS_DEF  = 64;
   localparam int DATA_WIDTH_DEF = 32;

   // fixed field widths on the ports
   localparam int CMD_W    = 1;
   localparam int SID_IN_W = 3;
   localparam int VAL_W    = 32;
   localparam int STAT_W   = 2;

   // request kinds
   localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
   localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

   // response status codes
   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/sps_ram.sv =====
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies
`default_nettype none

module sps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/shared_pool_multi_stack.sv =====
// shared pool multi-stack: several lifo stacks linked through one pool of slots
// depends on sps_pkg and sps_ram
`default_nettype none

// Several LIFO stacks share one pool of NUM_SLOTS slots. Each request transaction
// carries a push or a pop for one stack; each produces exactly one response
// transaction with a status (done, full on push, empty on pop) and, for a pop,
// the popped value (-1 on an empty stack, 0 for every push). A push or pop that
// goes through has its response loaded after these steps: the stack-top read
// issued at acceptance, a read of the slot-link memory (and, for a pop, of the
// slot-data memory), the link and pointer writes, and the response load, which
// waits until the output register is free. A push that finds the pool full or a
// pop that finds its stack empty skips the link step. The sequencer handles one
// request at a time and accepts the next request only once the previous one has
// loaded its response into the output register. A response waiting in the
// output register does not block acceptance of the next request, but that request
// cannot load its own response until the waiting one is taken. After reset all
// stacks are empty and the free list holds every slot in order. No clearing pass
// is needed: a high-water mark marks the slots never taken, whose link is implied.
// A stack number of NUM_STACKS or above changes nothing and answers full (push)
// or empty (pop). Pushed values keep their low DATA_WIDTH bits; popped values are
// sign-extended to 32 bits.

module shared_pool_multi_stack #(
   parameter int NUM_STACKS = sps_pkg::NUM_STACKS_DEF,
   parameter int NUM_SLOTS  = sps_pkg::NUM_SLOTS_DEF,
   parameter int DATA_WIDTH = sps_pkg::DATA_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] push_value
   input  wire logic [3:0]  req_tuser,   // [0] command, [3:1] stack_id
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // [31:0] pop_value
   output logic      [1:0]  rsp_tuser    // [1:0] status
);

   // pointer widths: null pointer is NUM_SLOTS
   localparam int PTR_W = $clog2(NUM_SLOTS + 1);
   localparam int AW    = $clog2(NUM_SLOTS);
   localparam int SID_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int SX_W  = (SID_W > sps_pkg::SID_IN_W) ? SID_W : sps_pkg::SID_IN_W;
   localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NUM_SLOTS);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;   // waiting for a request
   localparam logic [1:0] S_TOP  = 2'd1;   // stack top read back
   localparam logic [1:0] S_LINK = 2'd2;   // slot link read back
   localparam logic [1:0] S_DONE = 2'd3;   // result waits for output register

   logic [1:0]              state_ff, state_in;
   logic                    cmd_ff;
   logic [SID_W-1:0]        sid_ff;
   logic                    in_range_ff;
   logic [DATA_WIDTH-1:0]   value_ff;
   logic [PTR_W-1:0]        slot_ff, slot_in;
   logic [PTR_W-1:0]        top_old_ff, top_old_in;
   logic [PTR_W-1:0]        free_head_ff, free_head_in;
   logic [PTR_W-1:0]        hwm_ff, hwm_in;          // slots below this have a stored link
   logic [NUM_STACKS-1:0]   top_valid_ff, top_valid_in;
   logic [1:0]              res_status_ff, res_status_in;
   logic [31:0]             res_value_ff, res_value_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [31:0]             rsp_value_ff, rsp_value_in;

   logic                    accept;
   logic [SX_W-1:0]         req_sid_ext;
   logic                    req_in_range;
   logic [PTR_W-1:0]        top_cur;
   logic                    out_free;

   // memory ports
   logic                    top_we;
   logic [PTR_W-1:0]        top_wdata;
   logic [PTR_W-1:0]        top_rdata;
   logic                    link_we, link_re;
   logic [AW-1:0]           link_raddr;
   logic [PTR_W-1:0]        link_wdata;
   logic [PTR_W-1:0]        link_rdata;
   logic                    data_we, data_re;
   logic [DATA_WIDTH-1:0]   data_rdata;
   logic signed [63:0]      pop_wide;
   logic signed [63:0]      push_wide;

   assign req_tready   = (state_ff == S_IDLE);
   assign accept       = req_tvalid && req_tready;
   assign req_sid_ext  = SX_W'(req_tuser[3:1]);
   assign req_in_range = ({29'd0, req_tuser[3:1]} < 32'(NUM_STACKS));
   assign out_free     = !rsp_valid_ff || rsp_tready;

   // current top of the addressed stack, null when out of range or never written since reset
   assign top_cur = (in_range_ff && top_valid_ff[sid_ff]) ? top_rdata : NULL_PTR;

   // value conversions between port width and storage width
   assign push_wide = 64'(signed'(req_tdata));
   assign pop_wide  = 64'(signed'(data_rdata));

   // stack top memory: read at acceptance, written by a push or a pop
   sps_ram #(
      .WIDTH (PTR_W),
      .DEPTH (NUM_STACKS),
      .AW    (SID_W)
   ) u_top_ram (
      .clock   (clock),
      .wr_en   (top_we),
      .wr_addr (sid_ff),
      .wr_data (top_wdata),
      .rd_en   (accept),
      .rd_addr (req_sid_ext[SID_W-1:0]),
      .rd_data (top_rdata)
   );

   // slot link memory: next pointer of each slot in a stack or in the free list
   sps_ram #(
      .WIDTH (PTR_W),
      .DEPTH (NUM_SLOTS),
      .AW    (AW)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (slot_ff[AW-1:0]),
      .wr_data (link_wdata),
      .rd_en   (link_re),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   // slot data memory
   sps_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (NUM_SLOTS),
      .AW    (AW)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (free_head_ff[AW-1:0]),
      .wr_data (value_ff),
      .rd_en   (data_re),
      .rd_addr (top_cur[AW-1:0]),
      .rd_data (data_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      top_old_in    = top_old_ff;
      free_head_in  = free_head_ff;
      hwm_in        = hwm_ff;
      top_valid_in  = top_valid_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;

      top_we     = 1'b0;
      top_wdata  = free_head_ff;
      link_we    = 1'b0;
      link_re    = 1'b0;
      link_raddr = top_cur[AW-1:0];
      link_wdata = free_head_ff;
      data_we    = 1'b0;
      data_re    = 1'b0;

      // response register drains independently of the sequencer
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_TOP;
            end
         end

         S_TOP: begin
            if (cmd_ff == sps_pkg::CMD_PUSH) begin
               if (!in_range_ff || free_head_ff == NULL_PTR) begin
                  res_status_in = sps_pkg::STAT_FULL;
                  res_value_in  = '0;
                  state_in      = S_DONE;
               end else begin
                  // take the free head: store value, make it the new top
                  slot_in    = free_head_ff;
                  top_old_in = top_cur;
                  data_we    = 1'b1;
                  top_we     = 1'b1;
                  top_wdata  = free_head_ff;
                  top_valid_in[sid_ff] = 1'b1;
                  link_re    = 1'b1;
                  link_raddr = free_head_ff[AW-1:0];
                  state_in   = S_LINK;
               end
            end else begin
               if (!in_range_ff || top_cur == NULL_PTR) begin
                  res_status_in = sps_pkg::STAT_EMPTY;
                  res_value_in  = '1;
                  state_in      = S_DONE;
               end else begin
                  slot_in  = top_cur;
                  link_re  = 1'b1;
                  data_re  = 1'b1;
                  state_in = S_LINK;
               end
            end
         end

         S_LINK: begin
            link_we       = 1'b1;
            res_status_in = sps_pkg::STAT_DONE;
            if (cmd_ff == sps_pkg::CMD_PUSH) begin
               // slots at or above the high-water mark link to their successor
               if (slot_ff < hwm_ff) begin
                  free_head_in = link_rdata;
               end else begin
                  free_head_in = slot_ff + PTR_W'(1);
                  hwm_in       = hwm_ff + PTR_W'(1);
               end
               link_wdata   = top_old_ff;
               res_value_in = '0;
            end else begin
               // unlink the top and return it to the free head
               top_we       = 1'b1;
               top_wdata    = link_rdata;
               link_wdata   = free_head_ff;
               free_head_in = slot_ff;
               res_value_in = pop_wide[31:0];
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_head_ff <= '0;
         hwm_ff       <= '0;
         top_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         hwm_ff       <= hwm_in;
         top_valid_ff <= top_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= req_tuser[0];
         sid_ff      <= req_sid_ext[SID_W-1:0];
         in_range_ff <= req_in_range;
         value_ff    <= push_wide[DATA_WIDTH-1:0];
      end
      slot_ff       <= slot_in;
      top_old_ff    <= top_old_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

// ===== bench/tb_shared_pool_multi_stack.sv =====
// self-checking bench for shared_pool_multi_stack: push/pop transactions over the
// shared slot pool, checked against a cycle-free model of the stacks and free list
// depends on sps_pkg and shared_pool_multi_stack (with its memories)

module tb_shared_pool_multi_stack;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACKS      = sps_pkg::NUM_STACKS_DEF;
   localparam int SLOTS       = sps_pkg::NUM_SLOTS_DEF;
   localparam int SID_W       = sps_pkg::SID_IN_W;
   localparam int PTR_W       = $clog2(SLOTS + 1);
   localparam int NIL         = SLOTS;      // null pointer code
   localparam int IDLE_MAX    = 13;
   localparam int SETTLE      = 16;         // idle clocks after the last owed response comes back
   localparam int CYCLE_LIMIT = 300000;

   // one expected response transaction
   typedef struct packed {
      logic [sps_pkg::STAT_W-1:0] status;
      logic [sps_pkg::VAL_W-1:0]  value;
   } rsp_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [31:0]         req_tdata;   // [31:0] push_value
   logic [3:0]          req_tuser;   // [0] command, [3:1] stack_id
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [31:0]         rsp_tdata;   // [31:0] pop_value
   logic [1:0]          rsp_tuser;   // [1:0] status

   // mirror of the pool: slot contents, links, stack tops and free-list head
   logic [sps_pkg::VAL_W-1:0] slot_val  [SLOTS];
   logic [PTR_W-1:0]          slot_next [SLOTS];
   logic [PTR_W-1:0]          top_of    [STACKS];
   logic [PTR_W-1:0]          free_head;

   rsp_type             due_rsp[$];   // responses owed by the block, oldest first
   int                  errors;
   int                  cycle_count;
   int                  rsp_hold;     // cycles left with rsp_tready low
   bit                  quiet;        // no idling on either side

   shared_pool_multi_stack dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // every stack empty, free list chains all slots in order
   function automatic void clear_pool();
      for (int i = 0; i < SLOTS; i++) begin
         slot_val[i]  = '0;
         slot_next[i] = PTR_W'(i + 1);
      end
      for (int i = 0; i < STACKS; i++) top_of[i] = PTR_W'(NIL);
      free_head = '0;
   endfunction

   // perform one push or pop on the mirror and return the response it owes
   function automatic rsp_type apply_to_pool(logic [sps_pkg::CMD_W-1:0] cmd, int sid,
                                             logic [sps_pkg::VAL_W-1:0] val);
      rsp_type          r;
      logic [PTR_W-1:0] s;
      r.status = sps_pkg::STAT_DONE;
      r.value  = '0;
      if (cmd == sps_pkg::CMD_PUSH) begin
         if (sid >= STACKS || free_head == PTR_W'(NIL)) begin
            r.status = sps_pkg::STAT_FULL;
         end else begin
            // take the free-list head and link it above the old top
            s            = free_head;
            free_head    = slot_next[s];
            slot_val[s]  = val;
            slot_next[s] = top_of[sid];
            top_of[sid]  = s;
         end
      end else begin
         if (sid >= STACKS || top_of[sid] == PTR_W'(NIL)) begin
            r.status = sps_pkg::STAT_EMPTY;
            r.value  = '1;
         end else begin
            // unlink the top and hand it back to the free list
            s            = top_of[sid];
            top_of[sid]  = slot_next[s];
            slot_next[s] = free_head;
            free_head    = s;
            r.value      = slot_val[s];
         end
      end
      return r;
   endfunction

   // drive one request transaction after a random gap, wait for acceptance;
   // valid stays high afterwards so a back-to-back item keeps it asserted
   task automatic send_op(input logic [sps_pkg::CMD_W-1:0] cmd,
                          input logic [SID_W-1:0] sid,
                          input logic [sps_pkg::VAL_W-1:0] val);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, IDLE_MAX);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= val;
      req_tuser  <= {sid, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      due_rsp.push_back(apply_to_pool(cmd, int'(sid), val));
   endtask

   task automatic push_on(input int sid, input logic [sps_pkg::VAL_W-1:0] val);
      send_op(sps_pkg::CMD_PUSH, SID_W'(sid), val);
   endtask

   // the value field is ignored on a pop, so it carries noise
   task automatic pop_from(input int sid);
      send_op(sps_pkg::CMD_POP, SID_W'(sid), $urandom);
   endtask

   // hold off the sender until every owed response has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (due_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // pops right after reset find every stack empty
   task automatic test_empty_after_reset();
      pop_from(0);
      pop_from(STACKS - 1);
   endtask

   // extreme values come back intact and in lifo order, stacks sharing the pool
   task automatic test_lifo_extremes();
      push_on(3, 32'h8000_0000);
      push_on(0, 32'h5555_5555);
      push_on(3, 32'h7FFF_FFFF);
      push_on(3, 32'h0000_0000);
      push_on(0, 32'hAAAA_AAAA);
      push_on(3, 32'hFFFF_FFFF);
      push_on(7, 32'h0000_0001);
      for (int i = 0; i < 5; i++) pop_from(3);   // last one finds it empty
      for (int i = 0; i < 3; i++) pop_from(0);
      pop_from(7);
      pop_from(7);
      wait_drained();
   endtask

   // use up every slot, get full answers, then empty all stacks again
   task automatic test_pool_exhaustion();
      while (free_head != PTR_W'(NIL)) push_on($urandom_range(0, STACKS - 1), $urandom);
      for (int i = 0; i < 3; i++) push_on($urandom_range(0, STACKS - 1), $urandom);
      for (int s = 0; s < STACKS; s++) begin
         while (top_of[s] != PTR_W'(NIL)) pop_from(s);
         pop_from(s);
      end
      wait_drained();
   endtask

   // phases of mixed traffic: push bias swings so the pool fills and drains,
   // some phases crowd two stacks, some run with no idling at all
   task automatic test_random_traffic();
      int push_pct [9] = '{85, 60, 15, 90, 50, 30, 75, 10, 55};
      int sid;
      for (int ph = 0; ph < 9; ph++) begin
         quiet = (ph % 4 == 2);
         for (int n = 0; n < 110; n++) begin
            sid = (ph % 3 == 1) ? $urandom_range(0, 1) : $urandom_range(0, STACKS - 1);
            if ($urandom_range(0, 99) < push_pct[ph]) push_on(sid, $urandom);
            else pop_from(sid);
         end
         if (ph == 4) wait_drained();
      end
      quiet = 1'b0;
   endtask

   // response side: random stall per transaction, field-by-field check
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_rsp.size() == 0) begin
               errors++;
               $display("%0t: unexpected response, status %0d value %h", $time,
                        rsp_tuser, rsp_tdata);
            end else begin
               want = due_rsp.pop_front();
               if (rsp_tuser !== want.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, rsp_tuser);
               end
               if (rsp_tdata !== want.value) begin
                  errors++;
                  $display("%0t: pop_value expected %h actual %h", $time,
                           want.value, rsp_tdata);
               end
            end
            rsp_hold = quiet ? 0 : $urandom_range(0, IDLE_MAX);
            if (rsp_hold != 0) rsp_tready <= 1'b0;
         end else if (rsp_hold != 0) begin
            rsp_hold--;
            if (rsp_hold == 0) rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b1;
      rsp_hold   = 0;
      quiet      = 1'b0;
      errors     = 0;
      clear_pool();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_after_reset();
      test_lifo_extremes();
      test_pool_exhaustion();
      test_random_traffic();
      wait_drained();

      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
